@@ design/dense_sigmoid_layer_with_training_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dense sigmoid layer
// Shorthand forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DENSE_SIGMOID_LAYER_WITH_TRAINING_ASSERT_SVH
`define DENSE_SIGMOID_LAYER_WITH_TRAINING_ASSERT_SVH

// Overlapping implication, disabled while reset is asserted.
`define DSLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dslt: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dslt: assertion failed");

// Next-cycle implication that also holds across reset.
`define DSLT_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dslt: assertion failed");

`endif

@@ design/dslt_pkg.sv @@
// ----------------------------------------------------------------------------
// Dense sigmoid layer package
// Shared codes, widths and the sigmoid table generator.
// ----------------------------------------------------------------------------
package dslt_pkg;

    localparam int SIG_N     = 4096;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        ACT_WRITE,
        ACT_LOAD,
        ACT_EVAL,
        ACT_CORRECT
    } t_action;

    typedef enum logic [1:0] {
        CFG_NUM_NEURONS,
        CFG_NUM_INPUTS,
        CFG_LEARNING_RATE,
        CFG_UNUSED
    } t_cfg_index;

    typedef logic [15:0] t_sig_tab [SIG_N];

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [15:0] sig_entry(input logic [63:0] num, input logic [63:0] u32);
        logic [63:0] den;
        logic [63:0] q;
        den = 64'h1_0000_0000 + u32;
        q   = udiv64(64'd131070 * num + den, {den[62:0], 1'b0});
        return q[15:0];
    endfunction

    function automatic t_sig_tab build_sig_tab();
        t_sig_tab    tab;
        logic [63:0] term;
        logic [63:0] step;
        logic [63:0] u;
        logic [63:0] u32;
        term = 64'h4000_0000_0000_0000;
        step = 64'h4000_0000_0000_0000;
        u    = 64'h4000_0000_0000_0000;
        for (int n = 1; n <= 10; n++) begin
            term = udiv64(term, 64'(256 * n));
            if (n[0]) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        for (int k = 0; k <= 2048; k++) begin
            u32 = (u + 64'h2000_0000) >> 30;
            if (k <= 2047) begin
                tab[2048 + k] = sig_entry(64'h1_0000_0000, u32);
            end
            if (k >= 1) begin
                tab[2048 - k] = sig_entry(u32, u32);
            end
            u = mul_q62(u, step);
        end
        return tab;
    endfunction

    function automatic logic [11:0] sig_index(input logic signed [31:0] z);
        logic signed [27:0] q;
        q = 28'(z >>> 4);
        if ((&q[27:11]) || !(|q[27:11])) begin
            return {~q[11], q[10:0]};
        end
        return q[27] ? 12'h000 : 12'hfff;
    endfunction

endpackage

@@ design/dslt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dslt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dslt_sig_rom.sv @@
// ----------------------------------------------------------------------------
// Sigmoid table
// 4096-entry logistic table in unsigned Q0.16 with a registered read.
// ----------------------------------------------------------------------------
module dslt_sig_rom
    import dslt_pkg::*;
(
    input  logic        i_clk,
    input  logic [11:0] i_addr,
    output logic [15:0] o_data
);

    localparam t_sig_tab SIG_TAB = build_sig_tab();

    logic [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SIG_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ design/dense_sigmoid_layer_with_training.sv @@
// ----------------------------------------------------------------------------
// Dense sigmoid layer with delta-rule training
// Weight and input vectors sit in RAM; evaluate and correct walk them.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser action; tdata neuron, position, value, error, sum
//  m_axis    out        tdata neuron index, weighted sum, activation; tlast
//  cfg       in         register index and data, always ready
//
// Evaluate walks each neuron in turn through the single read port of the weight
// RAM; correct walks the row of the selected neuron.
// After reset the input RAM is cleared with tready low.
// A stalled result holds the walk before the next neuron is loaded.
// ----------------------------------------------------------------------------
module dense_sigmoid_layer_with_training
    import dslt_pkg::*;
#(
    parameter int NEURONS = 16,
    parameter int INPUTS  = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [1:0]           s_axis_tuser,  // action
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // neuron_select, position, value, error, sum_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // neuron_index, weighted_sum, activation
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int ROW  = INPUTS + 1;
    localparam int XW   = $clog2(INPUTS + 1);
    localparam int WA   = $clog2(NEURONS * ROW);
    localparam int AW   = (32 + XW > 45) ? 32 + XW : 45;
    localparam int MAXN = (NEURONS < 16) ? NEURONS : 16;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EVAL, S_EDRAIN, S_ESUM, S_ESIG, S_EOUT,
        S_CD, S_CR, S_CG, S_CGR, S_CWALK, S_CDRAIN
    } t_state;

    t_state r_state;

    logic [4:0]  r_cfg_nn;
    logic [10:0] r_cfg_ni;
    logic [15:0] r_rate;

    logic [XW-1:0] r_clr;
    logic [XW-1:0] r_j;
    logic [WA-1:0] r_base;
    logic [3:0]    r_n;
    logic          r_eval;

    logic               r_p1_v, r_p1_last, r_p2_v, r_p2_last;
    logic [WA-1:0]      r_p1_addr, r_p2_addr;
    logic signed [46:0] r_prod;
    logic signed [15:0] r_w2;

    logic signed [AW-1:0] r_acc;
    logic signed [31:0]   r_sum;
    logic signed [15:0]   r_err;
    logic [14:0]          r_d;
    logic [30:0]          r_rd;
    logic signed [47:0]   r_gp;
    logic signed [30:0]   r_g;

    logic        r_m_valid, r_m_last;
    logic [3:0]  r_m_idx;
    logic [31:0] r_m_sum;
    logic [15:0] r_m_act;

    logic [3:0]  w_nsel;
    logic [10:0] w_pos;
    logic [15:0] w_val;
    logic [15:0] w_errf;
    logic [31:0] w_zin;
    logic        w_s_acc;

    logic [4:0]    w_nn;
    logic [XW-1:0] w_ni;
    logic          w_issue;
    logic          w_nsel_ok;

    logic          w_we, w_xwe;
    logic [WA-1:0] w_waddr, w_raddr;
    logic [15:0]   w_wdata, w_wrdata;
    logic [XW-1:0] w_xaddr;
    logic [15:0]   w_xdata, w_xrdata;
    logic [11:0]   w_rom_addr;
    logic [15:0]   w_rom_data;

    logic signed [30:0]   w_ma;
    logic signed [46:0]   w_mul;
    logic signed [46:0]   w_delta;
    logic signed [19:0]   w_wnew;
    logic [15:0]          w_wsat;
    logic signed [AW-1:0] w_rnd;
    logic [31:0]          w_sat;
    logic [32:0]          w_dprod;

    assign w_nsel  = s_axis_tdata[3:0];
    assign w_pos   = s_axis_tdata[14:4];
    assign w_val   = s_axis_tdata[30:15];
    assign w_errf  = s_axis_tdata[46:31];
    assign w_zin   = s_axis_tdata[78:47];
    assign w_s_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {4'd0, r_m_act, r_m_sum, r_m_idx};

    always_comb begin
        if (r_cfg_nn == 5'd0) begin
            w_nn = 5'd1;
        end else if (32'(r_cfg_nn) > MAXN) begin
            w_nn = 5'(MAXN);
        end else begin
            w_nn = r_cfg_nn;
        end
        if (32'(r_cfg_ni) > INPUTS) begin
            w_ni = XW'(INPUTS);
        end else begin
            w_ni = XW'(r_cfg_ni);
        end
    end

    assign w_issue   = (r_state == S_EVAL) || (r_state == S_CWALK);
    assign w_nsel_ok = (32'(w_nsel) < NEURONS);
    assign w_raddr   = r_base + WA'(r_j);

    // Shared multiplier: weight times input on evaluate, gain times input on correct.
    assign w_ma  = r_eval ? 31'($signed(w_wrdata)) : r_g;
    assign w_mul = 47'(w_ma) * 47'($signed(w_xrdata));

    assign w_delta = (r_prod + 47'sd134217728) >>> 28;
    assign w_wnew  = 20'(r_w2) + 20'(w_delta);
    always_comb begin
        if ((&w_wnew[19:15]) || !(|w_wnew[19:15])) begin
            w_wsat = w_wnew[15:0];
        end else begin
            w_wsat = w_wnew[19] ? 16'h8000 : 16'h7fff;
        end
    end

    assign w_rnd = (r_acc + AW'(2048)) >>> 12;
    always_comb begin
        if ((&w_rnd[AW-1:31]) || !(|w_rnd[AW-1:31])) begin
            w_sat = w_rnd[31:0];
        end else begin
            w_sat = w_rnd[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
    end

    assign w_dprod = 33'(w_rom_data) * 33'(17'h10000 - 17'(w_rom_data));

    always_comb begin
        if (r_p2_v && !r_eval) begin
            w_we    = 1'b1;
            w_waddr = r_p2_addr;
            w_wdata = w_wsat;
        end else begin
            w_we    = w_s_acc && (s_axis_tuser == ACT_WRITE) && w_nsel_ok
                      && (32'(w_pos) <= INPUTS);
            w_waddr = WA'(w_nsel) * WA'(ROW) + WA'(w_pos);
            w_wdata = w_val;
        end
        if (r_state == S_CLEAR) begin
            w_xwe   = 1'b1;
            w_xaddr = r_clr;
            w_xdata = (r_clr == '0) ? 16'h1000 : 16'h0000;
        end else begin
            w_xwe   = w_s_acc && (s_axis_tuser == ACT_LOAD) && (w_pos != 11'd0)
                      && (32'(w_pos) <= INPUTS);
            w_xaddr = XW'(w_pos);
            w_xdata = w_val;
        end
        w_rom_addr = ((r_state == S_ESIG) || (r_state == S_EOUT)) ? sig_index(r_sum)
                                                                  : sig_index(w_zin);
    end

    dslt_ram #(.WIDTH(16), .DEPTH(NEURONS * ROW)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_wrdata)
    );

    dslt_ram #(.WIDTH(16), .DEPTH(ROW)) u_xmem (
        .i_clk   (i_clk),
        .i_we    (w_xwe),
        .i_waddr (w_xaddr),
        .i_wdata (w_xdata),
        .i_raddr (r_j),
        .o_rdata (w_xrdata)
    );

    dslt_sig_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cfg_nn  <= 5'd16;
            r_cfg_ni  <= 11'd1024;
            r_rate    <= 16'd655;
            r_clr     <= '0;
            r_j       <= '0;
            r_n       <= '0;
            r_eval    <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NUM_NEURONS:   r_cfg_nn <= i_cfg_data[4:0];
                    CFG_NUM_INPUTS:    r_cfg_ni <= i_cfg_data[10:0];
                    CFG_LEARNING_RATE: r_rate   <= i_cfg_data;
                    default:           ;
                endcase
            end

            r_p1_v    <= w_issue;
            r_p1_last <= (r_j == w_ni);
            r_p1_addr <= w_raddr;
            r_p2_v    <= r_p1_v;
            r_p2_last <= r_p1_last;
            r_p2_addr <= r_p1_addr;
            r_prod    <= w_mul;
            r_w2      <= $signed(w_wrdata);
            if (w_issue) begin
                r_j <= r_j + XW'(1);
            end
            if (r_p2_v && r_eval) begin
                r_acc <= r_acc + AW'($signed(r_prod[31:0]));
            end
            if (m_axis_tready && (r_state != S_EOUT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + XW'(1);
                    if (r_clr == XW'(INPUTS)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_s_acc && (s_axis_tuser == ACT_EVAL)) begin
                        r_eval  <= 1'b1;
                        r_n     <= '0;
                        r_j     <= '0;
                        r_base  <= '0;
                        r_acc   <= '0;
                        r_state <= S_EVAL;
                    end else if (w_s_acc && (s_axis_tuser == ACT_CORRECT) && w_nsel_ok) begin
                        r_eval  <= 1'b0;
                        r_j     <= '0;
                        r_base  <= WA'(w_nsel) * WA'(ROW);
                        r_err   <= $signed(w_errf);
                        r_state <= S_CD;
                    end
                end
                S_EVAL: begin
                    if (r_j == w_ni) begin
                        r_state <= S_EDRAIN;
                    end
                end
                S_EDRAIN: begin
                    if (r_p2_v && r_p2_last) begin
                        r_state <= S_ESUM;
                    end
                end
                S_ESUM: begin
                    r_sum   <= $signed(w_sat);
                    r_state <= S_ESIG;
                end
                S_ESIG: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_idx   <= r_n;
                        r_m_sum   <= r_sum;
                        r_m_act   <= w_rom_data;
                        r_m_last  <= ({1'b0, r_n} + 5'd1 == w_nn);
                        if ({1'b0, r_n} + 5'd1 == w_nn) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_n     <= r_n + 4'd1;
                            r_j     <= '0;
                            r_base  <= r_base + WA'(ROW);
                            r_acc   <= '0;
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_CD: begin
                    r_d     <= w_dprod[30:16];
                    r_state <= S_CR;
                end
                S_CR: begin
                    r_rd    <= 31'(r_rate) * 31'(r_d);
                    r_state <= S_CG;
                end
                S_CG: begin
                    r_gp    <= 48'($signed({1'b0, r_rd})) * 48'(r_err);
                    r_state <= S_CGR;
                end
                S_CGR: begin
                    r_g     <= 31'((r_gp + 48'sd32768) >>> 16);
                    r_state <= S_CWALK;
                end
                S_CWALK: begin
                    if (r_j == w_ni) begin
                        r_state <= S_CDRAIN;
                    end
                end
                S_CDRAIN: begin
                    if (r_p2_v && r_p2_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/dslt_checker.sv @@
// ----------------------------------------------------------------------------
// Dense sigmoid layer port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "dense_sigmoid_layer_with_training_assert.svh"

module dslt_checker
    import dslt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [1:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    `DSLT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `DSLT_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `DSLT_ASSERT_NXT(a_eval_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_EVAL), !s_axis_tready)
    `DSLT_ASSERT_NXT_ALL(a_clear_busy, i_clk, !i_rst_n, !s_axis_tready)

endmodule

bind dense_sigmoid_layer_with_training dslt_checker u_dslt_checker (.*);
